>>> hw/rtl/fvc_pkg.sv
// ============================================================================
// fvc_pkg
// shared types, widths and constants of the flywheel voltage controller
// ============================================================================
package fvc_pkg;

    localparam int TGT_W     = 14;
    localparam int MEAS_W    = 14;
    localparam int VOLT_W    = 15;
    localparam int ERR_W     = 15;
    localparam int PROD_W    = 32;
    localparam int FF_W      = 18;
    localparam int DIFF_W    = 19;
    localparam int SUM_W     = 16;
    localparam int FRAC_W    = 16;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int IN_DATA_W = 48;
    localparam int OUT_DATA_W = 32;

    localparam logic signed [VOLT_W-1:0] VMAX_MV = 15'sd12000;
    localparam logic [PROD_W:0]          ROUND_HALF = 33'd32768;

    typedef enum logic [1:0] {
        MODE_COAST    = 2'd0,
        MODE_VOLTAGE  = 2'd1,
        MODE_VELOCITY = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        CAND_SLEW,
        CAND_POS,
        CAND_NEG,
        CAND_ZERO
    } t_cand;

    typedef enum logic [2:0] {
        REG_CUSTOM_TUNING = 3'd0,
        REG_BANG_TOL      = 3'd1,
        REG_SLEW_LIMIT    = 3'd2,
        REG_FF_COEF       = 3'd3,
        REG_FULL_THR      = 3'd4,
        REG_COAST_THR     = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic        custom_tuning;
        logic [12:0] bang_tolerance;
        logic [13:0] slew_limit;
        logic [16:0] ff_coef;
        logic [12:0] full_thr;
        logic [12:0] coast_thr;
    } t_cfg;

    typedef struct packed {
        t_mode                     mode;
        t_cand                     cand;
        logic signed [TGT_W-1:0]   tgt;
        logic signed [VOLT_W-1:0]  old;
        logic signed [FF_W-1:0]    ff;
    } t_mid;

    function automatic logic signed [VOLT_W-1:0] cand_volt(input t_cand c);
        logic signed [VOLT_W-1:0] v;
        unique case (c)
            CAND_POS: v = VMAX_MV;
            CAND_NEG: v = -VMAX_MV;
            default:  v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/fvc_regs.sv
// ============================================================================
// fvc_regs
// apb register file holding the control law settings
// ============================================================================
module fvc_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fvc_pkg::ADDR_W-1:0]    paddr,
    input  logic [fvc_pkg::DATA_W-1:0]    pwdata,
    output logic [fvc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output fvc_pkg::t_cfg                 o_cfg
);

    fvc_pkg::t_cfg r_cfg;
    logic [2:0]    w_idx;

    assign w_idx  = paddr[4:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.custom_tuning  <= 1'b0;
            r_cfg.bang_tolerance <= 13'd500;
            r_cfg.slew_limit     <= 14'd5000;
            r_cfg.ff_coef        <= 17'd63898;
            r_cfg.full_thr       <= 13'd5900;
            r_cfg.coast_thr      <= 13'd200;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_idx)
                fvc_pkg::REG_CUSTOM_TUNING: r_cfg.custom_tuning  <= pwdata[0];
                fvc_pkg::REG_BANG_TOL:      r_cfg.bang_tolerance <= pwdata[12:0];
                fvc_pkg::REG_SLEW_LIMIT:    r_cfg.slew_limit     <= pwdata[13:0];
                fvc_pkg::REG_FF_COEF:       r_cfg.ff_coef        <= pwdata[16:0];
                fvc_pkg::REG_FULL_THR:      r_cfg.full_thr       <= pwdata[12:0];
                fvc_pkg::REG_COAST_THR:     r_cfg.coast_thr      <= pwdata[12:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            fvc_pkg::REG_CUSTOM_TUNING: prdata = 32'(r_cfg.custom_tuning);
            fvc_pkg::REG_BANG_TOL:      prdata = 32'(r_cfg.bang_tolerance);
            fvc_pkg::REG_SLEW_LIMIT:    prdata = 32'(r_cfg.slew_limit);
            fvc_pkg::REG_FF_COEF:       prdata = 32'(r_cfg.ff_coef);
            fvc_pkg::REG_FULL_THR:      prdata = 32'(r_cfg.full_thr);
            fvc_pkg::REG_COAST_THR:     prdata = 32'(r_cfg.coast_thr);
            default:                    prdata = '0;
        endcase
    end

endmodule

>>> hw/rtl/fvc_front.sv
// ============================================================================
// fvc_front
// stages one and two: feedforward product, rounding, law and mode selection
// ============================================================================
module fvc_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  fvc_pkg::t_cfg                        i_cfg,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [fvc_pkg::TGT_W-1:0]     i_tgt,
    input  logic signed [fvc_pkg::MEAS_W-1:0]    i_meas,
    input  logic signed [fvc_pkg::VOLT_W-1:0]    i_old,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output fvc_pkg::t_mid                        o_mid
);

    // stage 1
    logic                                  r_v1;
    logic signed [fvc_pkg::TGT_W-1:0]      r_tgt1;
    logic signed [fvc_pkg::VOLT_W-1:0]     r_old1;
    logic signed [fvc_pkg::PROD_W-1:0]     r_prod1;
    logic [fvc_pkg::ERR_W-1:0]             r_aerr1;
    logic                                  r_err_neg1;
    logic                                  r_err_pos1;
    logic [fvc_pkg::TGT_W-1:0]             r_atgt1;

    logic signed [fvc_pkg::PROD_W-1:0]     w_tgt_x;
    logic signed [fvc_pkg::PROD_W-1:0]     w_coef_x;
    logic signed [fvc_pkg::PROD_W-1:0]     n_prod;
    logic signed [fvc_pkg::ERR_W-1:0]      w_err;
    logic [fvc_pkg::ERR_W-1:0]             n_aerr;
    logic [fvc_pkg::TGT_W-1:0]             n_atgt;

    // stage 2
    logic                                  r_v2;
    fvc_pkg::t_mid                         r_mid2;

    logic [fvc_pkg::PROD_W-1:0]            w_aprod;
    logic [fvc_pkg::PROD_W:0]              w_rsum;
    logic [fvc_pkg::FF_W-1:0]              w_mag;
    fvc_pkg::t_mid                         n_mid;

    logic w_en1;
    logic w_en2;

    assign w_en2   = !r_v2 || i_ready;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;
    assign o_valid = r_v2;
    assign o_mid   = r_mid2;

    // product of target and twice the coefficient
    assign w_tgt_x  = fvc_pkg::PROD_W'(i_tgt);
    assign w_coef_x = $signed({14'd0, i_cfg.ff_coef, 1'b0});
    assign n_prod   = w_tgt_x * w_coef_x;
    assign w_err    = fvc_pkg::ERR_W'(i_tgt) - fvc_pkg::ERR_W'(i_meas);
    assign n_aerr   = w_err[fvc_pkg::ERR_W-1] ? fvc_pkg::ERR_W'(-w_err) : w_err;
    assign n_atgt   = i_tgt[fvc_pkg::TGT_W-1] ? fvc_pkg::TGT_W'(-i_tgt) : i_tgt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1 && i_valid) begin
            r_tgt1     <= i_tgt;
            r_old1     <= i_old;
            r_prod1    <= n_prod;
            r_aerr1    <= n_aerr;
            r_err_neg1 <= w_err[fvc_pkg::ERR_W-1];
            r_err_pos1 <= !w_err[fvc_pkg::ERR_W-1] && (w_err != '0);
            r_atgt1    <= n_atgt;
        end
    end

    // round to nearest, ties away from zero
    assign w_aprod = r_prod1[fvc_pkg::PROD_W-1] ? fvc_pkg::PROD_W'(-r_prod1) : r_prod1;
    assign w_rsum  = {1'b0, w_aprod} + fvc_pkg::ROUND_HALF;
    assign w_mag   = {1'b0, w_rsum[fvc_pkg::PROD_W:fvc_pkg::FRAC_W]};

    always_comb begin
        n_mid     = '0;
        n_mid.tgt = r_tgt1;
        n_mid.old = r_old1;
        n_mid.ff  = r_prod1[fvc_pkg::PROD_W-1] ? -$signed(w_mag) : $signed(w_mag);

        if (r_atgt1 >= {1'b0, i_cfg.full_thr}) begin
            if (r_tgt1 > 0) begin
                n_mid.cand = fvc_pkg::CAND_POS;
            end else if (r_tgt1 < 0) begin
                n_mid.cand = fvc_pkg::CAND_NEG;
            end else begin
                n_mid.cand = fvc_pkg::CAND_ZERO;
            end
        end else if (r_aerr1 > {2'b0, i_cfg.bang_tolerance}) begin
            if (r_tgt1 > 0) begin
                n_mid.cand = r_err_pos1 ? fvc_pkg::CAND_POS : fvc_pkg::CAND_ZERO;
            end else if (r_tgt1 < 0) begin
                n_mid.cand = r_err_neg1 ? fvc_pkg::CAND_NEG : fvc_pkg::CAND_ZERO;
            end else begin
                n_mid.cand = fvc_pkg::CAND_ZERO;
            end
        end else begin
            n_mid.cand = fvc_pkg::CAND_SLEW;
        end

        if (!i_cfg.custom_tuning) begin
            n_mid.mode = fvc_pkg::MODE_VELOCITY;
        end else if (r_atgt1 < {1'b0, i_cfg.coast_thr}) begin
            n_mid.mode = fvc_pkg::MODE_COAST;
        end else begin
            n_mid.mode = fvc_pkg::MODE_VOLTAGE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2 && r_v1) begin
            r_mid2 <= n_mid;
        end
    end

endmodule

>>> hw/rtl/fvc_back.sv
// ============================================================================
// fvc_back
// stages three and four: slew limit, voltage clamp and final command
// ============================================================================
module fvc_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [13:0]                          i_slew,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  fvc_pkg::t_mid                        i_mid,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output fvc_pkg::t_mode                       o_mode,
    output logic signed [fvc_pkg::VOLT_W-1:0]    o_volt,
    output logic signed [fvc_pkg::TGT_W-1:0]     o_vel
);

    // stage 3
    logic                                  r_v3;
    fvc_pkg::t_mode                        r_mode3;
    fvc_pkg::t_cand                        r_cand3;
    logic signed [fvc_pkg::TGT_W-1:0]      r_tgt3;
    logic signed [fvc_pkg::VOLT_W-1:0]     r_old3;
    logic signed [fvc_pkg::VOLT_W-1:0]     r_delta3;
    logic                                  r_cand_ok3;

    logic signed [fvc_pkg::DIFF_W-1:0]     w_diff;
    logic signed [fvc_pkg::DIFF_W-1:0]     w_slew_x;
    logic signed [fvc_pkg::VOLT_W-1:0]     n_delta;
    logic signed [fvc_pkg::SUM_W-1:0]      w_cdiff;
    logic [fvc_pkg::SUM_W-1:0]             w_acdiff;

    // stage 4
    logic                                  r_v4;
    fvc_pkg::t_mode                        r_mode;
    logic signed [fvc_pkg::VOLT_W-1:0]     r_volt;
    logic signed [fvc_pkg::TGT_W-1:0]      r_vel;

    logic signed [fvc_pkg::SUM_W-1:0]      w_sum;
    logic signed [fvc_pkg::VOLT_W-1:0]     w_nv;
    logic signed [fvc_pkg::VOLT_W-1:0]     n_volt;
    logic signed [fvc_pkg::TGT_W-1:0]      n_vel;

    logic w_en3;
    logic w_en4;

    assign w_en4   = !r_v4 || i_ready;
    assign w_en3   = !r_v3 || w_en4;
    assign o_ready = w_en3;
    assign o_valid = r_v4;
    assign o_mode  = r_mode;
    assign o_volt  = r_volt;
    assign o_vel   = r_vel;

    // step toward feedforward under the slew limit
    assign w_diff   = fvc_pkg::DIFF_W'(i_mid.ff) - fvc_pkg::DIFF_W'(i_mid.old);
    assign w_slew_x = $signed({5'd0, i_slew});

    always_comb begin
        if (w_diff > w_slew_x) begin
            n_delta = fvc_pkg::VOLT_W'(w_slew_x);
        end else if (w_diff < -w_slew_x) begin
            n_delta = fvc_pkg::VOLT_W'(-w_slew_x);
        end else begin
            n_delta = fvc_pkg::VOLT_W'(w_diff);
        end
    end

    assign w_cdiff  = fvc_pkg::SUM_W'(fvc_pkg::cand_volt(i_mid.cand))
                    - fvc_pkg::SUM_W'(i_mid.old);
    assign w_acdiff = w_cdiff[fvc_pkg::SUM_W-1] ? fvc_pkg::SUM_W'(-w_cdiff) : w_cdiff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en3) begin
            r_v3 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3 && i_valid) begin
            r_mode3    <= i_mid.mode;
            r_cand3    <= i_mid.cand;
            r_tgt3     <= i_mid.tgt;
            r_old3     <= i_mid.old;
            r_delta3   <= n_delta;
            r_cand_ok3 <= (w_acdiff <= {2'b0, i_slew});
        end
    end

    // clamp to full scale and pick the command
    assign w_sum = fvc_pkg::SUM_W'(r_old3) + fvc_pkg::SUM_W'(r_delta3);

    always_comb begin
        if (w_sum > fvc_pkg::SUM_W'(fvc_pkg::VMAX_MV)) begin
            w_nv = fvc_pkg::VMAX_MV;
        end else if (w_sum < -fvc_pkg::SUM_W'(fvc_pkg::VMAX_MV)) begin
            w_nv = -fvc_pkg::VMAX_MV;
        end else begin
            w_nv = fvc_pkg::VOLT_W'(w_sum);
        end
    end

    always_comb begin
        n_volt = '0;
        n_vel  = '0;
        unique case (r_mode3)
            fvc_pkg::MODE_VELOCITY: n_vel = r_tgt3;
            fvc_pkg::MODE_VOLTAGE: begin
                if (r_cand3 != fvc_pkg::CAND_SLEW && r_cand_ok3) begin
                    n_volt = fvc_pkg::cand_volt(r_cand3);
                end else begin
                    n_volt = w_nv;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_en4) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4 && r_v3) begin
            r_mode <= r_mode3;
            r_volt <= n_volt;
            r_vel  <= n_vel;
        end
    end

    a_coast_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && r_mode == fvc_pkg::MODE_COAST |-> r_volt == '0 && r_vel == '0)
        else $error("coast result carries a nonzero command");

    a_volt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && r_mode == fvc_pkg::MODE_VOLTAGE |->
            r_volt <= fvc_pkg::VMAX_MV && r_volt >= -fvc_pkg::VMAX_MV && r_vel == '0)
        else $error("voltage command outside full scale");

    a_vel_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && r_mode == fvc_pkg::MODE_VELOCITY |-> r_volt == '0)
        else $error("velocity result carries a voltage");

    a_s3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !w_en4 |=> r_v3 && $stable(r_delta3) && $stable(r_old3))
        else $error("stage three lost its request while stalled");

endmodule

>>> hw/rtl/flywheel_voltage_controller_unit.sv
// ============================================================================
// flywheel_voltage_controller_unit
// flywheel speed controller: feedforward with slew limit and bang-bang drive
// ============================================================================
// usage
//   s_axis carries one control tick per request: target speed, measured
//   speed and present motor voltage. m_axis returns one command per tick,
//   with the drive mode on tuser and voltage and velocity on tdata. the user
//   writes settings over the apb port while no tick is in flight (not enforced).
// pipeline
//   four register stages: product, rounding and law select, slew step,
//   final clamp and select. one request can be taken every cycle while
//   m_axis_tready is high.
// reset
//   synchronous active-low reset empties the pipeline and loads the
//   default settings: voltage law off, tolerance 500, slew 5000 mV,
//   coefficient 63898, full speed 5900, coast 200.
// stalls
//   when m_axis_tready is low the output holds and the stages behind it
//   keep filling; s_axis_tready drops only when all four stages are full.
// ============================================================================
module flywheel_voltage_controller_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fvc_pkg::ADDR_W-1:0]          paddr,
    input  logic [fvc_pkg::DATA_W-1:0]          pwdata,
    output logic [fvc_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // target_speed[13:0], measured_speed[27:14], present_voltage[42:28]
    input  logic [fvc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // drive_voltage[14:0], drive_velocity[28:15]
    output logic [fvc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // drive_mode[1:0]
    output logic [1:0]                          m_axis_tuser
);

    fvc_pkg::t_cfg                          w_cfg;
    fvc_pkg::t_mid                          w_mid;
    logic                                   w_mid_valid;
    logic                                   w_mid_ready;
    fvc_pkg::t_mode                         w_mode;
    logic signed [fvc_pkg::VOLT_W-1:0]      w_volt;
    logic signed [fvc_pkg::TGT_W-1:0]       w_vel;

    fvc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    fvc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_tgt   ($signed(s_axis_tdata[13:0])),
        .i_meas  ($signed(s_axis_tdata[27:14])),
        .i_old   ($signed(s_axis_tdata[42:28])),
        .o_valid (w_mid_valid),
        .i_ready (w_mid_ready),
        .o_mid   (w_mid)
    );

    fvc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_slew  (w_cfg.slew_limit),
        .i_valid (w_mid_valid),
        .o_ready (w_mid_ready),
        .i_mid   (w_mid),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_mode  (w_mode),
        .o_volt  (w_volt),
        .o_vel   (w_vel)
    );

    assign m_axis_tuser = w_mode;
    assign m_axis_tdata = {3'd0, w_vel, w_volt};

endmodule

>>> verif/fvc_scoreboard.sv
`timescale 1ns / 100ps
// ============================================================================
// fvc_scoreboard
// watches the apb and stream ports of the flywheel voltage controller, keeps
// its own copy of the settings, predicts each drive command from the tick
// request and compares it field by field with what the block returns
// ============================================================================
module fvc_scoreboard
    import fvc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [ADDR_W-1:0]     i_paddr,
    input  logic [DATA_W-1:0]     i_pwdata,
    input  logic                  i_tick_valid,
    input  logic                  i_tick_ready,
    input  logic [IN_DATA_W-1:0]  i_tick_data,
    input  logic                  i_cmd_valid,
    input  logic                  i_cmd_ready,
    input  logic [OUT_DATA_W-1:0] i_cmd_data,
    input  logic [1:0]            i_cmd_user,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_coast_seen,
    output int                    o_voltage_seen,
    output int                    o_velocity_seen
);

    typedef struct packed {
        t_mode                     mode;
        logic signed [VOLT_W-1:0]  volt;
        logic signed [TGT_W-1:0]   vel;
    } t_drive_cmd;

    logic        cfg_tuning;
    logic [12:0] cfg_bang;
    logic [13:0] cfg_slew;
    logic [16:0] cfg_coef;
    logic [12:0] cfg_full;
    logic [12:0] cfg_coast;

    t_drive_cmd  cmd_q[$];

    function automatic longint mag_of(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint limit(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic t_drive_cmd predict_command(input logic signed [TGT_W-1:0] tgt,
                                                   input logic signed [MEAS_W-1:0] meas,
                                                   input logic signed [VOLT_W-1:0] pres);
        t_drive_cmd c;
        longint t, m, p, err, slew, coef, full, bang, coast, cap;
        longint prod, mag, ff, nv, mv;
        t     = tgt;
        m     = meas;
        p     = pres;
        slew  = cfg_slew;
        coef  = cfg_coef;
        full  = cfg_full;
        bang  = cfg_bang;
        coast = cfg_coast;
        cap   = VMAX_MV;
        c.mode = MODE_COAST;
        c.volt = '0;
        c.vel  = '0;
        if (!cfg_tuning) begin
            c.mode = MODE_VELOCITY;
            c.vel  = tgt;
            return c;
        end
        err  = t - m;
        prod = t * 2 * coef;
        // round half away from zero
        mag  = (mag_of(prod) + 32768) >> 16;
        ff   = (prod < 0) ? -mag : mag;
        nv   = limit(p + limit(ff - p, -slew, slew), -cap, cap);
        if (mag_of(t) >= full) begin
            mv = (t > 0) ? cap : ((t < 0) ? -cap : 0);
        end else if (mag_of(err) > bang) begin
            if (t > 0)
                mv = (err > 0) ? cap : 0;
            else if (t < 0)
                mv = (err < 0) ? -cap : 0;
            else
                mv = 0;
        end else begin
            mv = nv;
        end
        if (mag_of(t) >= coast) begin
            c.mode = MODE_VOLTAGE;
            c.volt = (mag_of(mv - p) <= slew) ? mv : nv;
        end
        return c;
    endfunction

    task automatic flag(input string msg);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("%0t ns mismatch: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        t_drive_cmd got;
        t_drive_cmd want;
        if (!i_rst_n) begin
            cfg_tuning      = 1'b0;
            cfg_bang        = 13'd500;
            cfg_slew        = 14'd5000;
            cfg_coef        = 17'd63898;
            cfg_full        = 13'd5900;
            cfg_coast       = 13'd200;
            cmd_q.delete();
            o_fail_count    = 0;
            o_pending       = 0;
            o_coast_seen    = 0;
            o_voltage_seen  = 0;
            o_velocity_seen = 0;
        end else begin
            if (i_tick_valid && i_tick_ready)
                cmd_q.push_back(predict_command(i_tick_data[13:0], i_tick_data[27:14],
                                                i_tick_data[42:28]));
            if (i_cmd_valid && i_cmd_ready) begin
                got.mode = t_mode'(i_cmd_user);
                got.volt = i_cmd_data[14:0];
                got.vel  = i_cmd_data[28:15];
                case (got.mode)
                    MODE_COAST:    o_coast_seen++;
                    MODE_VOLTAGE:  o_voltage_seen++;
                    MODE_VELOCITY: o_velocity_seen++;
                    default: ;
                endcase
                if (cmd_q.size() == 0) begin
                    flag($sformatf("unexpected command mode %0d volt %0d vel %0d",
                                   got.mode, got.volt, got.vel));
                end else begin
                    want = cmd_q.pop_front();
                    if (got.mode !== want.mode || got.volt !== want.volt ||
                        got.vel !== want.vel)
                        flag($sformatf("expected mode %0d volt %0d vel %0d, got mode %0d volt %0d vel %0d",
                                       want.mode, want.volt, want.vel,
                                       got.mode, got.volt, got.vel));
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[ADDR_W-1:2])
                    REG_CUSTOM_TUNING: cfg_tuning = i_pwdata[0];
                    REG_BANG_TOL:      cfg_bang   = i_pwdata[12:0];
                    REG_SLEW_LIMIT:    cfg_slew   = i_pwdata[13:0];
                    REG_FF_COEF:       cfg_coef   = i_pwdata[16:0];
                    REG_FULL_THR:      cfg_full   = i_pwdata[12:0];
                    REG_COAST_THR:     cfg_coast  = i_pwdata[12:0];
                    default: ;
                endcase
            end
            o_pending = cmd_q.size();
        end
    end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// stimulus and verdict for the flywheel voltage controller: directed ticks
// for the pass-through, full speed, bang-bang, slew and coast paths, then
// random ticks under a series of settings with random stalls on both streams
// ============================================================================
module tb;
    import fvc_pkg::*;

    localparam int PIPE_DEPTH    = 4;
    localparam int SPARE_REG_IDX = 6;
    localparam int RAND_PHASES   = 12;
    localparam int PHASE_TICKS   = 106;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;

    int fail_count, pending, coast_seen, voltage_seen, velocity_seen;
    int cur_bang, cur_slew, cur_coef, cur_full, cur_coast;
    int n_sent, n_settings, hold_left, rx_cycle;
    bit calm;

    flywheel_voltage_controller_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    fvc_scoreboard u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_tick_valid    (s_axis_tvalid),
        .i_tick_ready    (s_axis_tready),
        .i_tick_data     (s_axis_tdata),
        .i_cmd_valid     (m_axis_tvalid),
        .i_cmd_ready     (m_axis_tready),
        .i_cmd_data      (m_axis_tdata),
        .i_cmd_user      (m_axis_tuser),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_coast_seen    (coast_seen),
        .o_voltage_seen  (voltage_seen),
        .o_velocity_seen (velocity_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // command side back-pressure
    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm && (rx_cycle / 48) % 3 != 0 && $urandom_range(0, 7) == 0) begin
            hold_left     <= $urandom_range(0, 4);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic int fit(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    task automatic reg_write(input int idx, input int val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_settings(input int tun, input int b, input int s, input int c,
                                  input int f, input int k);
        reg_write(REG_CUSTOM_TUNING, tun);
        reg_write(REG_BANG_TOL, b);
        reg_write(REG_SLEW_LIMIT, s);
        reg_write(REG_FF_COEF, c);
        reg_write(REG_FULL_THR, f);
        reg_write(REG_COAST_THR, k);
        cur_bang   = b;
        cur_slew   = s;
        cur_coef   = c;
        cur_full   = f;
        cur_coast  = k;
        n_settings++;
    endtask

    task automatic send_tick(input int tgt, input int meas, input int pres);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, 15'(pres), 14'(meas), 14'(tgt)};
        do @(posedge i_clk); while (!s_axis_tready);
        n_sent++;
        if (!calm && (n_sent / 32) % 3 != 0 && $urandom_range(0, 5) == 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge i_clk);
        end
    endtask

    // hold requests until every command is back
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic int pick_setting(input int width, input int high, input int dflt);
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return high;
            2:       return (1 << width) - 1;
            3:       return dflt;
            default: return $urandom_range(0, high);
        endcase
    endfunction

    task automatic random_settings(input int n);
        if (n == 0)
            apply_settings(1, 0, 0, 0, 0, 0);
        else if (n == 1)
            apply_settings(1, 6000, 12000, 131071, 6000, 6000);
        else if (n == 2)
            apply_settings(1, 8191, 16383, 131071, 8191, 8191);
        else
            apply_settings($urandom_range(0, 6) != 0, pick_setting(13, 6000, 500),
                           pick_setting(14, 12000, 5000), pick_setting(17, 131071, 63898),
                           pick_setting(13, 6000, 5900), pick_setting(13, 6000, 200));
    endtask

    task automatic random_tick();
        int r, sgn, tgt, meas, pres;
        longint ffe;
        r   = $urandom_range(0, 99);
        sgn = $urandom_range(0, 1) ? 1 : -1;
        if (r < 8) begin
            tgt = $urandom_range(0, 16383) - 8192;
        end else if (r < 20) begin
            case ($urandom_range(0, 4))
                0:       tgt = sgn * 6000;
                1:       tgt = 0;
                2:       tgt = sgn * cur_full;
                3:       tgt = sgn * cur_coast;
                default: tgt = sgn * (cur_coast - 1);
            endcase
            tgt = fit(tgt, -8192, 8191);
        end else begin
            tgt = $urandom_range(0, 12000) - 6000;
        end
        r = $urandom_range(0, 99);
        if (r < 50)
            meas = fit(tgt + $urandom_range(0, 2 * cur_bang + 2) - (cur_bang + 1), -8192, 8191);
        else if (r < 60)
            meas = $urandom_range(0, 16383) - 8192;
        else
            meas = $urandom_range(0, 14000) - 7000;
        ffe = (longint'(tgt) * 2 * cur_coef) >>> 16;
        r   = $urandom_range(0, 99);
        if (r < 10)
            pres = $urandom_range(0, 32767) - 16384;
        else if (r < 25)
            pres = sgn * 12000;
        else if (r < 55)
            pres = fit(int'(ffe) + $urandom_range(0, 2 * cur_slew + 2) - (cur_slew + 1),
                       -16384, 16383);
        else
            pres = $urandom_range(0, 24000) - 12000;
        send_tick(tgt, meas, pres);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b1;
        hold_left     = 0;
        rx_cycle      = 0;
        calm          = 1'b0;
        n_sent        = 0;
        n_settings    = 1;
        cur_bang      = 500;
        cur_slew      = 5000;
        cur_coef      = 63898;
        cur_full      = 5900;
        cur_coast     = 200;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: velocity pass-through, write to an unused slot ignored
        reg_write(SPARE_REG_IDX, 1);
        send_tick(-8192, 8191, -16384);
        send_tick(8191, -8192, 16383);
        send_tick(0, 0, 0);
        send_tick(-6000, 7000, 12000);
        send_tick(6000, -7000, -12000);
        drain();

        // voltage law at default tuning
        reg_write(REG_CUSTOM_TUNING, 1);
        send_tick(6000, 0, 0);
        send_tick(6000, 0, 11000);
        send_tick(-6000, 0, -12000);
        send_tick(3000, 0, 8000);
        send_tick(3000, 0, 0);
        send_tick(3000, 5000, 2000);
        send_tick(-3000, 0, -1000);
        send_tick(-3000, -6000, -9000);
        send_tick(3000, 3000, 0);
        send_tick(100, 0, 0);
        send_tick(-199, 0, 500);
        send_tick(200, 200, 0);
        send_tick(3000, 3000, 16383);
        send_tick(-3000, -3000, -16384);
        send_tick(5000, 8191, 0);
        send_tick(-5000, -8192, 0);
        drain();

        // zero target with full speed forced everywhere
        apply_settings(1, 500, 5000, 63898, 0, 0);
        send_tick(0, 0, 3000);
        drain();

        // bang-bang with zero target
        apply_settings(1, 500, 5000, 63898, 6000, 0);
        send_tick(0, 3000, 1000);
        send_tick(0, -3000, -1000);
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            random_settings(ph);
            if (ph == RAND_PHASES - 1)
                calm = 1'b1;
            repeat (PHASE_TICKS) random_tick();
            drain();
        end

        repeat (PIPE_DEPTH + 4) @(negedge i_clk);
        $display("ran %0d control ticks under %0d settings", n_sent, n_settings);
        $display("commands seen: %0d coast, %0d voltage, %0d velocity",
                 coast_seen, voltage_seen, velocity_seen);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/fvc_pkg.sv
hw/rtl/fvc_regs.sv
hw/rtl/fvc_front.sv
hw/rtl/fvc_back.sv
hw/rtl/flywheel_voltage_controller_unit.sv
verif/fvc_scoreboard.sv
verif/tb.sv
